>>> rtl/slht_pkg.sv
// ----------------------------------------------------------------------------
// Sound level hue tracker package
// Shared field widths, command and register codes, and the sequencer states.
// ----------------------------------------------------------------------------
package slht_pkg;

   localparam int CMD_W       = 2;
   localparam int SAMPLE_W    = 10;
   localparam int LEVEL_W     = 10;
   localparam int OFFSET_W    = 8;
   localparam int GAIN_W      = 8;
   localparam int WEIGHT_W    = 9;
   localparam int GAP_W       = 12;
   localparam int SCALED_W    = 20;
   localparam int HUE_OUT_W   = 7;
   localparam int DIFF_W      = 11;
   localparam int WHEEL_OUT_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam int HUE_TOP = 120;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd230;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_END_WINDOW = 2'd1,
      CMD_UPDATE     = 2'd2,
      CMD_STEP       = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEVEL_OFFSET = 2'd0,
      CSR_LEVEL_GAIN   = 2'd1,
      CSR_EMA_WEIGHT   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WIN_DIV,
      ST_EMA_GO,
      ST_WIN_EMA,
      ST_GAIN,
      ST_INC_DIV,
      ST_DONE
   } state_type;

endpackage

>>> rtl/slht_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module slht_divider #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : DIVISOR_W'(trial);
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/slht_ema.sv
// ----------------------------------------------------------------------------
// Serial moving average update
// Forms (fresh * (full - w) + old * w) >> scale with one weight bit per cycle.
// ----------------------------------------------------------------------------
module slht_ema
   import slht_pkg::*;
#(
   parameter int EMA_SCALE_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [LEVEL_W-1:0]  old_level,
   input  logic [LEVEL_W-1:0]  fresh_level,
   input  logic [WEIGHT_W-1:0] old_weight,
   output logic                done,
   output logic [LEVEL_W-1:0]  result
);

   localparam int WGT_W  = EMA_SCALE_BITS + 1;
   localparam int CMP_W  = (WGT_W > WEIGHT_W) ? WGT_W : WEIGHT_W;
   localparam int ACC_W  = LEVEL_W + WGT_W;
   localparam int STEP_W = $clog2(WGT_W + 1);
   localparam logic [CMP_W-1:0] FULL_CMP = CMP_W'(1) << EMA_SCALE_BITS;
   localparam logic [WGT_W-1:0] FULL     = WGT_W'(1) << EMA_SCALE_BITS;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WGT_W-1:0]    w_ff, w_in;
   logic [WGT_W-1:0]    nw_ff, nw_in;
   logic [ACC_W-1:0]    old_sh_ff, old_sh_in;
   logic [ACC_W-1:0]    fresh_sh_ff, fresh_sh_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CMP_W-1:0]    w_ext;
   logic [WGT_W-1:0]    w_eff;

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      w_in        = w_ff;
      nw_in       = nw_ff;
      old_sh_in   = old_sh_ff;
      fresh_sh_in = fresh_sh_ff;
      acc_in      = acc_ff;
      w_ext       = CMP_W'(old_weight);
      w_eff       = (w_ext > FULL_CMP) ? FULL : WGT_W'(w_ext);
      if (start) begin
         busy_in     = 1'b1;
         step_in     = STEP_W'(WGT_W);
         w_in        = w_eff;
         nw_in       = FULL - w_eff;
         old_sh_in   = ACC_W'(old_level);
         fresh_sh_in = ACC_W'(fresh_level);
         acc_in      = '0;
      end else if (busy_ff) begin
         acc_in      = acc_ff + (w_ff[0] ? old_sh_ff : '0) + (nw_ff[0] ? fresh_sh_ff : '0);
         w_in        = w_ff >> 1;
         nw_in       = nw_ff >> 1;
         old_sh_in   = old_sh_ff << 1;
         fresh_sh_in = fresh_sh_ff << 1;
         step_in     = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      w_ff        <= w_in;
      nw_ff       <= nw_in;
      old_sh_ff   <= old_sh_in;
      fresh_sh_ff <= fresh_sh_in;
      acc_ff      <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[EMA_SCALE_BITS +: LEVEL_W];

endmodule

>>> rtl/sound_level_hue_tracker.sv
// ----------------------------------------------------------------------------
// Sound level hue tracker
// Window statistics, moving averages of mean and peak, and hue animation.
// ----------------------------------------------------------------------------
// One request beat in, exactly one response beat out. A sample or an animation
// step moves to ST_DONE and from there into the response register. An end of
// window runs the serial divider for the window mean (skipped if the window is
// empty) and then both bit-serial average units together; a hue target update
// forms the scaled level gap and then runs the serial divider for the step.
// A new request is taken once the previous one has reached the response
// register, even while that response is stalled.
module sound_level_hue_tracker
   import slht_pkg::*;
#(
   parameter int WINDOW_MAX     = 1024,
   parameter int LED_COUNT      = 24,
   parameter int HUE_FRAC_BITS  = 10,
   parameter int EMA_SCALE_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [SAMPLE_W-1:0]       req_sample_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [HUE_OUT_W-1:0]      rsp_hue,
   output logic [LEVEL_W-1:0]        rsp_average_level,
   output logic [LEVEL_W-1:0]        rsp_peak_level,
   output logic signed [DIFF_W-1:0]  rsp_level_difference,
   output logic [WHEEL_OUT_W-1:0]    rsp_wheel_position
);

   localparam int SUM_W   = $clog2(WINDOW_MAX * 1023 + 1);
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int HUE_MAX = HUE_TOP << HUE_FRAC_BITS;
   localparam int HUE_W   = $clog2(HUE_MAX + 1);
   localparam int INC_W   = HUE_W + 1;
   localparam int SUMH_W  = HUE_W + 2;
   localparam int LED_W   = $clog2(LED_COUNT + 1);
   localparam int WHEEL_W = $clog2(LED_COUNT);
   localparam int DIV_N   = (SUM_W > HUE_W) ? SUM_W : HUE_W;
   localparam int DIV_D   = (CNT_W > LED_W) ? CNT_W : LED_W;

   state_type                 state_ff, state_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic signed [GAIN_W-1:0]  gain_ff, gain_in;
   logic [WEIGHT_W-1:0]       weight_ff, weight_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [LEVEL_W-1:0]        wpeak_ff, wpeak_in;
   logic [LEVEL_W-1:0]        mean_avg_ff, mean_avg_in;
   logic [LEVEL_W-1:0]        peak_avg_ff, peak_avg_in;
   logic [HUE_W-1:0]          hue_ff, hue_in;
   logic signed [INC_W-1:0]   inc_ff, inc_in;
   logic [WHEEL_W-1:0]        wheel_ff, wheel_in;
   logic [WHEEL_W-1:0]        wheel_before_ff, wheel_before_in;
   logic [LEVEL_W-1:0]        mean_ff, mean_in;
   logic signed [SCALED_W-1:0] lvl_ff, lvl_in;
   logic                      neg_ff, neg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [HUE_OUT_W-1:0]      rsp_hue_ff, rsp_hue_in;
   logic [LEVEL_W-1:0]        rsp_avg_ff, rsp_avg_in;
   logic [LEVEL_W-1:0]        rsp_peak_ff, rsp_peak_in;
   logic signed [DIFF_W-1:0]  rsp_diff_ff, rsp_diff_in;
   logic [WHEEL_OUT_W-1:0]    rsp_wheel_ff, rsp_wheel_in;

   logic                      req_accept;
   logic                      rsp_load;
   cmd_type                   cmd;
   logic                      div_start;
   logic                      div_done;
   logic [DIV_N-1:0]          div_dividend;
   logic [DIV_D-1:0]          div_divisor;
   logic [DIV_N-1:0]          div_quotient;
   logic                      ema_start;
   logic                      mean_done;
   logic                      peak_done;
   logic [LEVEL_W-1:0]        mean_result;
   logic [LEVEL_W-1:0]        peak_result;
   logic signed [GAP_W-1:0]   gap;
   logic [HUE_OUT_W-1:0]      lvl_clamped;
   logic [HUE_W-1:0]          target;
   logic signed [HUE_W:0]     hue_diff;
   logic [HUE_W:0]            hue_diff_mag;
   logic [INC_W-1:0]          inc_mag;
   logic signed [SUMH_W-1:0]  hue_sum;

   assign cmd = cmd_type'(req_command);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_stall  = (state_ff != ST_IDLE);
      req_accept = req_valid && (state_ff == ST_IDLE);
      div_start  = 1'b0;
      ema_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (cmd)
                  CMD_END_WINDOW: begin
                     if (count_ff != '0) begin
                        div_start = 1'b1;
                        state_in  = ST_WIN_DIV;
                     end else begin
                        state_in  = ST_EMA_GO;
                     end
                  end
                  CMD_UPDATE: state_in = ST_GAIN;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_WIN_DIV: begin
            if (div_done) begin
               state_in = ST_EMA_GO;
            end
         end
         ST_EMA_GO: begin
            ema_start = 1'b1;
            state_in  = ST_WIN_EMA;
         end
         ST_WIN_EMA: begin
            if (mean_done && peak_done) begin
               state_in = ST_DONE;
            end
         end
         ST_GAIN: begin
            div_start = 1'b1;
            state_in  = ST_INC_DIV;
         end
         ST_INC_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hue target arithmetic
   always_comb begin
      gap = $signed({2'b00, peak_avg_ff}) - $signed({2'b00, mean_avg_ff})
            - GAP_W'(offset_ff);
      if (lvl_ff < 0) begin
         lvl_clamped = '0;
      end else if (lvl_ff > SCALED_W'(HUE_TOP)) begin
         lvl_clamped = HUE_OUT_W'(HUE_TOP);
      end else begin
         lvl_clamped = lvl_ff[HUE_OUT_W-1:0];
      end
      target       = HUE_W'(HUE_OUT_W'(HUE_TOP) - lvl_clamped) << HUE_FRAC_BITS;
      hue_diff     = $signed({1'b0, target}) - $signed({1'b0, hue_ff});
      hue_diff_mag = hue_diff[HUE_W] ? (HUE_W + 1)'(-hue_diff) : hue_diff;
      inc_mag      = {1'b0, div_quotient[HUE_W-1:0]};
      hue_sum      = $signed({2'b00, hue_ff}) + SUMH_W'(inc_ff);
   end

   assign div_dividend = (state_ff == ST_GAIN) ? DIV_N'(hue_diff_mag[HUE_W-1:0])
                                               : DIV_N'(sum_ff);
   assign div_divisor  = (state_ff == ST_GAIN) ? DIV_D'(LED_COUNT) : DIV_D'(count_ff);

   // datapath
   always_comb begin
      offset_in       = offset_ff;
      gain_in         = gain_ff;
      weight_in       = weight_ff;
      sum_in          = sum_ff;
      count_in        = count_ff;
      wpeak_in        = wpeak_ff;
      mean_avg_in     = mean_avg_ff;
      peak_avg_in     = peak_avg_ff;
      hue_in          = hue_ff;
      inc_in          = inc_ff;
      wheel_in        = wheel_ff;
      wheel_before_in = wheel_before_ff;
      mean_in         = mean_ff;
      lvl_in          = lvl_ff;
      neg_in          = neg_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_hue_in      = rsp_hue_ff;
      rsp_avg_in      = rsp_avg_ff;
      rsp_peak_in     = rsp_peak_ff;
      rsp_diff_in     = rsp_diff_ff;
      rsp_wheel_in    = rsp_wheel_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LEVEL_OFFSET: offset_in = csr_wdata[OFFSET_W-1:0];
            CSR_LEVEL_GAIN:   gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_EMA_WEIGHT:   weight_in = csr_wdata[WEIGHT_W-1:0];
            default:          ;
         endcase
      end

      if (req_accept) begin
         wheel_before_in = wheel_ff;
         case (cmd)
            CMD_SAMPLE: begin
               if (count_ff < CNT_W'(WINDOW_MAX)) begin
                  sum_in   = sum_ff + SUM_W'(req_sample_value);
                  count_in = count_ff + CNT_W'(1);
                  if (req_sample_value > wpeak_ff) begin
                     wpeak_in = req_sample_value;
                  end
               end
            end
            CMD_END_WINDOW: mean_in = '0;
            CMD_UPDATE:     lvl_in  = SCALED_W'(gap) * SCALED_W'(gain_ff);
            default: begin
               if (hue_sum < 0) begin
                  hue_in = '0;
               end else if (hue_sum > SUMH_W'(HUE_MAX)) begin
                  hue_in = HUE_W'(HUE_MAX);
               end else begin
                  hue_in = hue_sum[HUE_W-1:0];
               end
               wheel_in = (wheel_ff == WHEEL_W'(LED_COUNT - 1)) ? '0
                                                               : wheel_ff + WHEEL_W'(1);
            end
         endcase
      end

      if (state_ff == ST_WIN_DIV && div_done) begin
         mean_in = div_quotient[LEVEL_W-1:0];
      end
      if (state_ff == ST_WIN_EMA && mean_done && peak_done) begin
         mean_avg_in = mean_result;
         peak_avg_in = peak_result;
         sum_in      = '0;
         count_in    = '0;
         wpeak_in    = '0;
      end
      if (state_ff == ST_GAIN) begin
         neg_in = hue_diff[HUE_W];
      end
      if (state_ff == ST_INC_DIV && div_done) begin
         inc_in = neg_ff ? $signed(-inc_mag) : $signed(inc_mag);
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hue_in   = hue_ff[HUE_FRAC_BITS +: HUE_OUT_W];
         rsp_avg_in   = mean_avg_ff;
         rsp_peak_in  = peak_avg_ff;
         rsp_diff_in  = $signed(DIFF_W'(peak_avg_ff) - DIFF_W'(mean_avg_ff));
         rsp_wheel_in = WHEEL_OUT_W'(wheel_before_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= '0;
         gain_ff      <= GAIN_RESET;
         weight_ff    <= WEIGHT_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         wpeak_ff     <= '0;
         mean_avg_ff  <= '0;
         peak_avg_ff  <= '0;
         hue_ff       <= HUE_W'(HUE_MAX);
         inc_ff       <= '0;
         wheel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         gain_ff      <= gain_in;
         weight_ff    <= weight_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         wpeak_ff     <= wpeak_in;
         mean_avg_ff  <= mean_avg_in;
         peak_avg_ff  <= peak_avg_in;
         hue_ff       <= hue_in;
         inc_ff       <= inc_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wheel_before_ff <= wheel_before_in;
      mean_ff         <= mean_in;
      lvl_ff          <= lvl_in;
      neg_ff          <= neg_in;
      rsp_hue_ff      <= rsp_hue_in;
      rsp_avg_ff      <= rsp_avg_in;
      rsp_peak_ff     <= rsp_peak_in;
      rsp_diff_ff     <= rsp_diff_in;
      rsp_wheel_ff    <= rsp_wheel_in;
   end

   slht_divider #(
      .DIVIDEND_W (DIV_N),
      .DIVISOR_W  (DIV_D)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   slht_ema #(
      .EMA_SCALE_BITS (EMA_SCALE_BITS)
   ) u_mean_ema (
      .clock       (clock),
      .reset       (reset),
      .start       (ema_start),
      .old_level   (mean_avg_ff),
      .fresh_level (mean_ff),
      .old_weight  (weight_ff),
      .done        (mean_done),
      .result      (mean_result)
   );

   slht_ema #(
      .EMA_SCALE_BITS (EMA_SCALE_BITS)
   ) u_peak_ema (
      .clock       (clock),
      .reset       (reset),
      .start       (ema_start),
      .old_level   (peak_avg_ff),
      .fresh_level (wpeak_ff),
      .old_weight  (weight_ff),
      .done        (peak_done),
      .result      (peak_result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hue              = rsp_hue_ff;
   assign rsp_average_level    = rsp_avg_ff;
   assign rsp_peak_level       = rsp_peak_ff;
   assign rsp_level_difference = rsp_diff_ff;
   assign rsp_wheel_position   = rsp_wheel_ff;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Sound level hue tracker testbench
// The bench pushes sample, window-end, hue-update and animation-step beats
// into the tracker under random valid and stall gaps. A local model of the
// window statistics, moving averages and hue animation predicts every
// response beat. Several register settings are covered, the extremes among
// them.
// ----------------------------------------------------------------------------
module tb_top;
   import slht_pkg::*;

   localparam int WINDOW_MAX     = 1024;
   localparam int LED_COUNT      = 24;
   localparam int HUE_FRAC_BITS  = 10;
   localparam int EMA_SCALE_BITS = 8;
   localparam int EMA_FULL       = 1 << EMA_SCALE_BITS;
   localparam int HUE_CEILING    = HUE_TOP << HUE_FRAC_BITS;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      cmd_type             cmd;
      logic [SAMPLE_W-1:0] sample;
   } req_beat_t;

   typedef struct packed {
      logic [HUE_OUT_W-1:0]   hue;
      logic [LEVEL_W-1:0]     average;
      logic [LEVEL_W-1:0]     peak;
      logic [DIFF_W-1:0]      diff;
      logic [WHEEL_OUT_W-1:0] wheel;
   } level_report_t;

   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     csr_we           = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index        = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata        = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command      = '0;
   logic [SAMPLE_W-1:0]      req_sample_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic [HUE_OUT_W-1:0]     rsp_hue;
   logic [LEVEL_W-1:0]       rsp_average_level;
   logic [LEVEL_W-1:0]       rsp_peak_level;
   logic signed [DIFF_W-1:0] rsp_level_difference;
   logic [WHEEL_OUT_W-1:0]   rsp_wheel_position;

   sound_level_hue_tracker #(
      .WINDOW_MAX    (WINDOW_MAX),
      .LED_COUNT     (LED_COUNT),
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .EMA_SCALE_BITS(EMA_SCALE_BITS)
   ) dut (.*);

   // tracker model state and register copies
   logic [19:0]         win_sum;
   logic [10:0]         win_count;
   logic [LEVEL_W-1:0]  win_peak;
   logic [LEVEL_W-1:0]  mean_avg;
   logic [LEVEL_W-1:0]  peak_avg;
   int                  hue_fx;
   int                  hue_step;
   logic [4:0]          wheel;
   logic signed [7:0]   cfg_offset;
   logic signed [7:0]   cfg_gain;
   logic [8:0]          cfg_weight;

   req_beat_t     pending_reqs[$];
   level_report_t expected_reports[$];
   bit            idle_enable = 1'b1;
   int            queued_beats = 0;
   int            beats_sent = 0;
   int            beats_checked = 0;
   int            mismatches = 0;
   int            settings_used = 0;
   int            cycle_count = 0;
   int            cmd_count[4] = '{0, 0, 0, 0};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [LEVEL_W-1:0] ema_blend(logic [LEVEL_W-1:0] old_avg,
                                                    logic [LEVEL_W-1:0] fresh);
      int w;
      int acc;
      w   = (int'(cfg_weight) > EMA_FULL) ? EMA_FULL : int'(cfg_weight);
      acc = int'(fresh) * (EMA_FULL - w) + int'(old_avg) * w;
      return LEVEL_W'(acc >> EMA_SCALE_BITS);
   endfunction

   function automatic level_report_t predict_report(cmd_type cmd,
                                                    logic [SAMPLE_W-1:0] sample);
      level_report_t r;
      int            mean;
      int            gap;
      int            lvl;
      int            target;
      r.wheel = wheel;
      case (cmd)
         CMD_SAMPLE: begin
            if (int'(win_count) < WINDOW_MAX) begin
               win_sum   = win_sum + 20'(sample);
               win_count = win_count + 11'd1;
               if (sample > win_peak) win_peak = sample;
            end
         end
         CMD_END_WINDOW: begin
            mean      = (win_count != 0) ? int'(win_sum) / int'(win_count) : 0;
            mean_avg  = ema_blend(mean_avg, LEVEL_W'(mean));
            peak_avg  = ema_blend(peak_avg, win_peak);
            win_sum   = '0;
            win_count = '0;
            win_peak  = '0;
         end
         CMD_UPDATE: begin
            gap = int'(peak_avg) - int'(mean_avg) - int'(cfg_offset);
            lvl = gap * int'(cfg_gain);
            if (lvl < 0) lvl = 0;
            if (lvl > HUE_TOP) lvl = HUE_TOP;
            target   = (HUE_TOP - lvl) << HUE_FRAC_BITS;
            hue_step = (target - hue_fx) / LED_COUNT;
         end
         CMD_STEP: begin
            hue_fx = hue_fx + hue_step;
            if (hue_fx < 0) hue_fx = 0;
            if (hue_fx > HUE_CEILING) hue_fx = HUE_CEILING;
            wheel = (int'(wheel) == LED_COUNT - 1) ? '0 : wheel + 5'd1;
         end
      endcase
      r.hue     = HUE_OUT_W'(hue_fx >> HUE_FRAC_BITS);
      r.average = mean_avg;
      r.peak    = peak_avg;
      r.diff    = {1'b0, peak_avg} - {1'b0, mean_avg};
      return r;
   endfunction

   function automatic void queue_beat(cmd_type cmd, logic [SAMPLE_W-1:0] sample);
      req_beat_t b;
      b.cmd    = cmd;
      b.sample = sample;
      pending_reqs.push_back(b);
      queued_beats++;
   endfunction

   // request driver
   always @(posedge clock) begin
      req_beat_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_reports.push_back(predict_report(cmd_type'(req_command),
                                                      req_sample_value));
            cmd_count[req_command]++;
            beats_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && !(idle_enable && $urandom_range(99) < 32)) begin
               nxt = pending_reqs.pop_front();
               req_valid        <= 1'b1;
               req_command      <= nxt.cmd;
               req_sample_value <= nxt.sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      level_report_t got;
      level_report_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_hue, rsp_average_level, rsp_peak_level,
                   rsp_level_difference, rsp_wheel_position};
            beats_checked++;
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"tb_top: response beat with none expected: ",
                            "hue %0d avg %0d peak %0d diff %0d wheel %0d"},
                           got.hue, got.average, got.peak, $signed(got.diff), got.wheel);
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"tb_top: beat %0d mismatch (exp/got): hue %0d/%0d ",
                               "avg %0d/%0d peak %0d/%0d diff %0d/%0d wheel %0d/%0d"},
                              beats_checked, want.hue, got.hue, want.average, got.average,
                              want.peak, got.peak, $signed(want.diff), $signed(got.diff),
                              want.wheel, got.wheel);
               end
            end
         end
         rsp_stall <= idle_enable && ($urandom_range(99) < 32);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: timeout, %0d beats still expected", expected_reports.size());
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic program_levels(logic signed [7:0] off, logic signed [7:0] gain,
                                 logic [8:0] weight);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_LEVEL_OFFSET;
      csr_wdata <= {1'b0, off};
      @(posedge clock);
      csr_index <= CSR_LEVEL_GAIN;
      csr_wdata <= {1'b0, gain};
      @(posedge clock);
      csr_index <= CSR_EMA_WEIGHT;
      csr_wdata <= weight;
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_offset  = off;
      cfg_gain    = gain;
      cfg_weight  = weight;
      settings_used++;
      @(negedge clock);
   endtask

   // mostly whole windows, each followed by an optional target update and a run of steps
   task automatic queue_traffic(int count);
      int stop_at;
      int n;
      int k;
      stop_at = queued_beats + count;
      while (queued_beats < stop_at) begin
         if ($urandom_range(99) < 75) begin
            n = $urandom_range(24, 1);
            for (k = 0; k < n; k++)
               queue_beat(CMD_SAMPLE, ($urandom_range(99) < 10) ? 10'h3FF
                                      : SAMPLE_W'($urandom_range(1023)));
            queue_beat(CMD_END_WINDOW, SAMPLE_W'($urandom));
            if ($urandom_range(99) < 60) queue_beat(CMD_UPDATE, SAMPLE_W'($urandom));
            n = ($urandom_range(99) < 15) ? 40 : $urandom_range(28);
            for (k = 0; k < n; k++) queue_beat(CMD_STEP, SAMPLE_W'($urandom));
         end else begin
            n = $urandom_range(4, 1);
            for (k = 0; k < n; k++)
               queue_beat(cmd_type'(CMD_W'($urandom_range(3))), SAMPLE_W'($urandom));
         end
      end
   endtask

   task automatic drain;
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_reports.size() > 0);
   endtask

   initial begin
      int k;
      win_sum    = '0;
      win_count  = '0;
      win_peak   = '0;
      mean_avg   = '0;
      peak_avg   = '0;
      hue_fx     = HUE_CEILING;
      hue_step   = 0;
      wheel      = '0;
      cfg_offset = 8'sd0;
      cfg_gain   = 8'(GAIN_RESET);
      cfg_weight = WEIGHT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty windows, sample extremes, every command
      queue_beat(CMD_END_WINDOW, 10'h3FF);
      queue_beat(CMD_UPDATE, 10'h000);
      queue_beat(CMD_STEP, 10'h3FF);
      queue_beat(CMD_SAMPLE, 10'h000);
      queue_beat(CMD_SAMPLE, 10'h3FF);
      queue_beat(CMD_SAMPLE, 10'h001);
      queue_beat(CMD_SAMPLE, 10'h200);
      queue_beat(CMD_SAMPLE, 10'h3FF);
      queue_beat(CMD_END_WINDOW, 10'h155);
      queue_beat(CMD_UPDATE, 10'h2AA);
      for (k = 0; k < 6; k++) queue_beat(CMD_STEP, 10'h000);
      queue_beat(CMD_SAMPLE, 10'h155);
      queue_beat(CMD_SAMPLE, 10'h2AA);
      queue_beat(CMD_END_WINDOW, 10'h000);
      queue_beat(CMD_END_WINDOW, 10'h3FF);
      queue_beat(CMD_UPDATE, 10'h000);
      for (k = 0; k < 3; k++) queue_beat(CMD_STEP, 10'h3FF);
      drain();

      program_levels(-8'sd128, 8'sd127, 9'd0);
      queue_traffic(65);
      drain();

      program_levels(8'sd127, -8'sd128, 9'd256);
      queue_traffic(65);
      drain();

      program_levels(8'sd5, 8'sd3, 9'd511);
      queue_traffic(60);
      drain();

      idle_enable = 1'b0;
      program_levels(8'($urandom), 8'($urandom), 9'($urandom_range(300)));
      queue_traffic(65);
      drain();
      idle_enable = 1'b1;

      program_levels(-8'sd20, 8'sd2, 9'd200);
      queue_traffic(65);
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb_top: %0d request beats (%0d samples, %0d window ends, %0d updates, %0d steps)",
               beats_sent, cmd_count[CMD_SAMPLE], cmd_count[CMD_END_WINDOW],
               cmd_count[CMD_UPDATE], cmd_count[CMD_STEP]);
      $display("tb_top: %0d response beats checked over %0d register settings, %0d mismatches",
               beats_checked, settings_used + 1, mismatches);
      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
